// File: rtl/point_window_merge_sort_decimate_assert.svh
// ----------------------------------------------------------------------------
// Point window merge sort decimate assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POINT_WINDOW_MERGE_SORT_DECIMATE_ASSERT_SVH
`define POINT_WINDOW_MERGE_SORT_DECIMATE_ASSERT_SVH

// same-cycle implication
`define PWMSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PWMSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/pwmsd_pkg.sv
// ----------------------------------------------------------------------------
// Point window merge sort decimate package
// Word types, cell entry and control types, codes and field widths.
// ----------------------------------------------------------------------------
package pwmsd_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned OFFS_W = 32;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CAP_W  = 7;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] scan_base_time;
    logic [OFFS_W-1:0] point_offset;
    logic [DATA_W-1:0] payload_low;
    logic [DATA_W-1:0] payload_high;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] merged_base_time;
    logic [OFFS_W-1:0] merged_offset;
    logic [DATA_W-1:0] out_payload_low;
    logic [DATA_W-1:0] out_payload_high;
    logic [CAP_W-1:0]  emitted_count;
    logic              last_point;
    logic              dropped_flag;
  } out_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] abs_time;
    logic [DATA_W-1:0] pay_lo;
    logic [DATA_W-1:0] pay_hi;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

endpackage

// File: rtl/point_window_merge_sort_decimate.sv
// ----------------------------------------------------------------------------
// Point window merge sort decimate
// Time-ordered point window with rebased offsets and uniform decimation.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one word per point or flush.
// A point word is inserted into a chain of CAPACITY cells kept in ascending
// absolute time; point words are taken back to back, one per cycle, while
// idle. Points past capacity are dropped and flagged for the window.
// A flush word starts a drain: the chain shifts toward cell 0 once per cycle
// unless the receiver stalls, and cell 0 is sent out when its position is
// selected, floor(i*n/cap); the input stalls until the drain is done. The
// first output word goes from cell 0 to the output register once the state
// register holds the drain state. An empty window emits nothing and idles.
// Output channel (out_valid_o / out_stall_i) is a single output register;
// while the receiver stalls, the drain holds and nothing is lost.
// point_cap is written via cfg_we_i / cfg_wdata_i, by the user only while
// idle; the block does not enforce it. Reset empties the window and clears
// cap and out_valid_o; cells and out word keep data, fill count marks cells.
// ----------------------------------------------------------------------------
`include "point_window_merge_sort_decimate_assert.svh"

module point_window_merge_sort_decimate #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pwmsd_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pwmsd_pkg::in_word_t            in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pwmsd_pkg::out_word_t           out_word_o
);
  import pwmsd_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = $clog2(CAPACITY * CAPACITY + 1);

  state_e            state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic [CW-1:0]     count_q, count_d;
  logic [TIME_W-1:0] least_q, least_d;
  logic              ovf_q, ovf_d;
  logic [CW-1:0]     emit_q, emit_d;
  logic [CW-1:0]     sent_q, sent_d;
  logic [NW-1:0]     num_q, num_d;
  logic [NW-1:0]     pe_q, pe_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  logic              in_acc, add_acc, flush_acc, full, adv, sel, draining;
  entry_t            new_entry;
  cell_ctl_t         ctl;
  entry_t            cell_e [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign add_acc    = in_acc && (in_word_i.func == FUNC_ADD);
  assign flush_acc  = in_acc && (in_word_i.func == FUNC_FLUSH);
  assign full       = (count_q == CW'(CAPACITY));
  assign adv        = !out_valid_q || !out_stall_i;
  assign draining   = (state_q == ST_DRAIN) && (sent_q != emit_q);
  assign sel        = num_q < (pe_q + NW'(emit_q));

  assign new_entry.abs_time = in_word_i.scan_base_time + TIME_W'(in_word_i.point_offset);
  assign new_entry.pay_lo   = in_word_i.payload_low;
  assign new_entry.pay_hi   = in_word_i.payload_high;

  assign ctl.ins   = add_acc && !full;
  assign ctl.shift = draining && adv;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_gt;
    if (gi == 0) begin : g_first
      assign left_e  = new_entry;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = cell_e[gi-1];
      assign left_gt = cell_gt[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_e = cell_e[gi];
    end else begin : g_inner
      assign right_e = cell_e[gi+1];
    end
    pwmsd_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .valid_i   (CW'(gi) < count_q),
      .new_i     (new_entry),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .entry_o   (cell_e[gi]),
      .gt_o      (cell_gt[gi])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    least_d     = least_q;
    ovf_d       = ovf_q;
    emit_d      = emit_q;
    sent_d      = sent_q;
    num_d       = num_q;
    pe_d        = pe_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (add_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
            if (in_word_i.scan_base_time < least_q) begin
              least_d = in_word_i.scan_base_time;
            end
          end
        end else if (flush_acc) begin
          if ((cap_q != '0) && (8'(count_q) > 8'(cap_q))) begin
            emit_d = CW'(cap_q);
          end else begin
            emit_d = count_q;
          end
          sent_d  = '0;
          num_d   = '0;
          pe_d    = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sent_q == emit_q) begin
          count_d = '0;
          least_d = '1;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else if (adv) begin
          pe_d = pe_q + NW'(emit_q);
          if (sel) begin
            out_valid_d            = 1'b1;
            out_d.merged_base_time = least_q;
            out_d.merged_offset    = cell_e[0].abs_time[OFFS_W-1:0] - least_q[OFFS_W-1:0];
            out_d.out_payload_low  = cell_e[0].pay_lo;
            out_d.out_payload_high = cell_e[0].pay_hi;
            out_d.emitted_count    = CAP_W'(emit_q);
            out_d.last_point       = (sent_q + CW'(1)) == emit_q;
            out_d.dropped_flag     = ovf_q;
            num_d                  = num_q + NW'(count_q);
            sent_d                 = sent_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= '0;
      count_q     <= '0;
      least_q     <= '1;
      ovf_q       <= 1'b0;
      emit_q      <= '0;
      sent_q      <= '0;
      num_q       <= '0;
      pe_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      least_q     <= least_d;
      ovf_q       <= ovf_d;
      emit_q      <= emit_d;
      sent_q      <= sent_d;
      num_q       <= num_d;
      pe_q        <= pe_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `PWMSD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
  `PWMSD_ASSERT_IMP(a_sent_bound, state_q == ST_DRAIN, sent_q <= emit_q)
  `PWMSD_ASSERT_NXT(a_flush_drain, flush_acc, state_q == ST_DRAIN)
  `PWMSD_ASSERT_NXT(a_emit_loads, draining && adv && sel, out_valid_q)

endmodule

// File: rtl/pwmsd_cell.sv
// ----------------------------------------------------------------------------
// Sort chain cell
// Holds one entry; inserts, shifts right on insert, shifts left on drain.
// ----------------------------------------------------------------------------
module pwmsd_cell (
  input  logic                             clk_i,
  input  pwmsd_pkg::cell_ctl_t             ctl_i,
  input  logic                             valid_i,
  input  pwmsd_pkg::entry_t                new_i,
  input  pwmsd_pkg::entry_t                left_i,
  input  logic                             left_gt_i,
  input  pwmsd_pkg::entry_t                right_i,
  output pwmsd_pkg::entry_t                entry_o,
  output logic                             gt_o
);
  import pwmsd_pkg::*;

  entry_t entry_q, entry_d;

  assign gt_o    = !valid_i || (entry_q.abs_time > new_i.abs_time);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = right_i;
    end else if (ctl_i.ins && gt_o) begin
      entry_d = left_gt_i ? left_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: dv/point_window_merge_sort_decimate_checker.sv
// ----------------------------------------------------------------------------
// Point window merge sort decimate checker
// Watches the config port and both channels, keeps its own time-sorted copy
// of the point window, works out every output word that a flush word causes
// and compares each output word with the oldest one still waiting.
// ----------------------------------------------------------------------------
module point_window_merge_sort_decimate_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pwmsd_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  pwmsd_pkg::in_word_t         in_word_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  pwmsd_pkg::out_word_t        out_word_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import pwmsd_pkg::*;

  logic [TIME_W-1:0] win_time [CAPACITY];
  logic [DATA_W-1:0] win_lo [CAPACITY];
  logic [DATA_W-1:0] win_hi [CAPACITY];
  int unsigned       win_fill;
  logic [TIME_W-1:0] win_least_base;
  logic              win_overflow;
  logic [CAP_W-1:0]  cap_reg;
  out_word_t         window_out_q[$];
  out_word_t         want_word;
  int                errors = 0;
  int                pending = 0;

  assign fail_count_o = errors;
  assign pending_o    = pending;

  function automatic void clear_window();
    win_fill       = 0;
    win_least_base = '1;
    win_overflow   = 1'b0;
  endfunction

  function automatic void place_point(in_word_t w);
    logic [TIME_W-1:0] t;
    int                pos;
    t = w.scan_base_time + w.point_offset;
    if (win_fill >= CAPACITY) begin
      win_overflow = 1'b1;
      return;
    end
    pos = win_fill;
    while (pos > 0 && win_time[pos-1] > t) begin
      win_time[pos] = win_time[pos-1];
      win_lo[pos]   = win_lo[pos-1];
      win_hi[pos]   = win_hi[pos-1];
      pos--;
    end
    win_time[pos] = t;
    win_lo[pos]   = w.payload_low;
    win_hi[pos]   = w.payload_high;
    win_fill++;
    if (w.scan_base_time < win_least_base) win_least_base = w.scan_base_time;
  endfunction

  function automatic void drain_window();
    int unsigned       n;
    int unsigned       emit;
    int unsigned       idx;
    logic [TIME_W-1:0] diff;
    out_word_t         r;
    n    = win_fill;
    emit = (cap_reg != 0 && n > cap_reg) ? cap_reg : n;
    for (int unsigned i = 0; i < emit; i++) begin
      idx                = (emit == n) ? i : (i * n) / emit;
      diff               = win_time[idx] - win_least_base;
      r.merged_base_time = win_least_base;
      r.merged_offset    = diff[OFFS_W-1:0];
      r.out_payload_low  = win_lo[idx];
      r.out_payload_high = win_hi[idx];
      r.emitted_count    = CAP_W'(emit);
      r.last_point       = (i + 1 == emit);
      r.dropped_flag     = win_overflow;
      window_out_q.insert(window_out_q.size(), r);
    end
    clear_window();
  endfunction

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_window();
      cap_reg = '0;
      window_out_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (window_out_q.size() == 0) begin
          $error("output word with none expected: %0h", out_word_i);
          errors++;
        end else begin
          want_word = window_out_q.pop_front();
          cmp_field("merged_base_time", want_word.merged_base_time,
                    out_word_i.merged_base_time);
          cmp_field("merged_offset", want_word.merged_offset, out_word_i.merged_offset);
          cmp_field("out_payload_low", want_word.out_payload_low,
                    out_word_i.out_payload_low);
          cmp_field("out_payload_high", want_word.out_payload_high,
                    out_word_i.out_payload_high);
          cmp_field("emitted_count", want_word.emitted_count, out_word_i.emitted_count);
          cmp_field("last_point", want_word.last_point, out_word_i.last_point);
          cmp_field("dropped_flag", want_word.dropped_flag, out_word_i.dropped_flag);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.func == FUNC_FLUSH) drain_window();
        else place_point(in_word_i);
      end
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      pending = window_out_q.size();
    end
  end

endmodule

// File: dv/point_window_merge_sort_decimate_tb.sv
// ----------------------------------------------------------------------------
// Point window merge sort decimate testbench
// Drives directed windows (empty flush, time ties, wrapped times, decimation
// caps at both ends) and then random windows of mixed size with bursty input,
// patterned output stall and one long output hold-off that backs up the input.
// The checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module point_window_merge_sort_decimate_tb;
  import pwmsd_pkg::*;

  localparam int     CAPACITY      = 64;
  localparam int     HALF_PERIOD   = 10;
  localparam int     RESET_CYCLES  = 7;
  localparam int     ITEM_TARGET   = 410;
  localparam int     LONG_HOLD     = 300;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     END_CYCLES    = 80;
  localparam int     PRESSURE_WIN  = 4;
  localparam longint TIMEOUT       = 64'd20_000_000;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;
  int               fail_count;
  int               pending;
  int               hold_requests = 0;
  int               words_sent = 0;
  int               burst_left = 1;
  bit               steady = 1'b0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  point_window_merge_sort_decimate #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  point_window_merge_sort_decimate_checker #(
    .CAPACITY(CAPACITY)
  ) checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_word_t point_word(logic [63:0] base, logic [31:0] offs,
                                          logic [63:0] lo, logic [63:0] hi);
    in_word_t w;
    w.func           = FUNC_ADD;
    w.scan_base_time = base;
    w.point_offset   = offs;
    w.payload_low    = lo;
    w.payload_high   = hi;
    return w;
  endfunction

  function automatic in_word_t flush_word();
    in_word_t w;
    w      = point_word(rand64(), $urandom(), rand64(), rand64());
    w.func = FUNC_FLUSH;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic settle(input int slack);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (slack) @(negedge clk_i);
  endtask

  task automatic write_point_cap(input logic [CAP_W-1:0] value);
    settle(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_window(input int size, input bit hold_out);
    int          style;
    int          nscan;
    logic [63:0] scan0;
    logic [63:0] base;
    logic [31:0] offs;
    style = $urandom_range(0, 2);
    nscan = $urandom_range(1, 4);
    scan0 = rand64();
    for (int k = 0; k < size; k++) begin
      case (style)
        0: begin
          base = rand64();
          offs = $urandom();
        end
        1: begin
          base = scan0 + 64'($urandom_range(0, nscan - 1)) * 64'd100_000;
          offs = $urandom_range(0, 250_000);
        end
        default: begin
          base = scan0 + 64'($urandom_range(0, 1));
          offs = $urandom_range(0, 2);
        end
      endcase
      send_word(point_word(base, offs, rand64(), rand64()));
    end
    if (hold_out) hold_requests++;
    send_word(flush_word());
  endtask

  initial begin : receiver
    int mode;
    int span;
    int tick;
    int holds_done;
    tick       = 0;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        if (hold_requests > holds_done) begin
          holds_done++;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(negedge clk_i);
          out_stall <= 1'b0;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= ((tick % 5) < 2);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int       win;
    int       pick;
    int       size;
    in_word_t noise;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    send_word(flush_word());
    send_word(point_word(64'd1000, 32'd50, '0, '0));
    send_word(point_word(64'd1000, 32'd50, '1, '1));
    send_word(point_word(64'd900, 32'd0, rand64(), rand64()));
    send_word(point_word('1, '1, rand64(), rand64()));
    send_word(point_word('0, '0, rand64(), rand64()));
    send_word(point_word(64'd5, '1, rand64(), rand64()));
    send_word(flush_word());

    write_point_cap(CAP_W'(3));
    for (int k = 0; k < 6; k++)
      send_word(point_word(64'h7000 + 64'($urandom_range(0, 3)), $urandom_range(0, 9),
                           rand64(), rand64()));
    send_word(flush_word());

    write_point_cap(CAP_W'(CAPACITY));
    send_window(3, 1'b0);
    write_point_cap(CAP_W'(1));
    send_window(2, 1'b0);

    write_point_cap('0);
    win = 0;
    while (words_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if (win != PRESSURE_WIN + 1 && $urandom_range(0, 99) < 30) begin
        case ($urandom_range(0, 4))
          0:       write_point_cap('0);
          1:       write_point_cap(CAP_W'(1));
          2:       write_point_cap(CAP_W'(CAPACITY));
          3:       write_point_cap(CAP_W'(2));
          default: write_point_cap(CAP_W'($urandom_range(1, CAPACITY)));
        endcase
      end
      pick = $urandom_range(0, 99);
      if (win == PRESSURE_WIN) size = CAPACITY + 3;
      else if (pick < 10) size = 0;
      else if (pick < 65) size = $urandom_range(1, 10);
      else if (pick < 85) size = $urandom_range(11, 40);
      else size = $urandom_range(CAPACITY - 4, CAPACITY + 8);
      send_window(size, win == PRESSURE_WIN);
      if ($urandom_range(0, 9) == 0) begin
        noise      = point_word(rand64(), $urandom(), rand64(), rand64());
        noise.func = 1'($urandom_range(0, 1));
        send_word(noise);
      end
      win++;
    end

    settle(END_CYCLES);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pwmsd_pkg.sv
rtl/pwmsd_cell.sv
rtl/point_window_merge_sort_decimate.sv
dv/point_window_merge_sort_decimate_checker.sv
dv/point_window_merge_sort_decimate_tb.sv
